>>> hw/rtl/leg_inverse_kinematics_defines.svh
// Assertion macros for the checker file of the leg inverse kinematics block.
// No dependencies; included by the checker module only.
`ifndef LEG_INVERSE_KINEMATICS_DEFINES_SVH
`define LEG_INVERSE_KINEMATICS_DEFINES_SVH

// Implication in the same cycle, disabled while reset is asserted.
`define LIK_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Implication in the next cycle, disabled while reset is asserted.
`define LIK_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/lik_pkg.sv
// Package of the leg inverse kinematics block: types, constants and per-stage functions.
// No dependencies; used by lik_pipe, leg_inverse_kinematics and lik_checker.
`default_nettype none

package lik_pkg;

    localparam int ANGLE_FRAC_BITS_DEF   = 12;
    localparam int CORDIC_ITERATIONS_DEF = 16;
    localparam int CORDIC_MAX_ITER       = 24;
    localparam int SQRT_BITS             = 25;
    localparam int DIV_BITS              = 25;
    localparam int S_TDATA_W             = 48;
    localparam int M_TDATA_W             = 48;
    localparam int CFG_INDEX_W           = 3;
    localparam int CFG_DATA_W            = 16;

    localparam logic signed [36:0] PI_Q30      = 37'sd3373259426;
    localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [25:0] COS_ONE     = 26'sd16777216;
    localparam logic [49:0]        SQ_ONE      = 50'd281474976710656;

    localparam logic [29:0] ATAN_Q30 [0:CORDIC_MAX_ITER-1] = '{
        30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
        30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
        30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
        30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255, 30'd127
    };

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_COXA   = 3'd0,
        REG_FEMUR  = 3'd1,
        REG_TIBIA  = 3'd2,
        REG_OFF_X  = 3'd3,
        REG_OFF_Y  = 3'd4,
        REG_COSINE = 3'd5,
        REG_SINE   = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [12:0]        coxa;
        logic [12:0]        femur;
        logic [12:0]        tibia;
        logic signed [13:0] off_x;
        logic signed [13:0] off_y;
        logic signed [15:0] cosine;
        logic signed [15:0] sine;
    } cfg_t;

    typedef struct packed {
        logic [49:0] rem;
        logic [24:0] root;
    } sq_t;

    typedef struct packed {
        logic        neg;
        logic        dz;
        logic        sat;
        logic [37:0] den;
        logic [63:0] rem;
        logic [24:0] q;
    } dv_t;

    typedef struct packed {
        logic signed [35:0] x;
        logic signed [35:0] y;
        logic signed [34:0] ang;
        logic               zero;
    } cr_t;

    typedef struct packed {
        logic signed [15:0] rel_x;
        logic signed [15:0] rel_y;
        logic signed [19:0] pz;
        logic signed [31:0] m_xc;
        logic signed [31:0] m_ys;
        logic signed [31:0] m_yc;
        logic signed [31:0] m_xs;
        logic signed [22:0] px;
        logic signed [22:0] py;
        logic [48:0]        sa;
        logic [48:0]        sb;
        sq_t [1:0]          sq;
        logic signed [25:0] radial;
        logic [18:0]        reach;
        logic               ok;
        logic               rz;
        logic [35:0]        r2;
        logic [35:0]        f2;
        logic [35:0]        t2;
        logic [35:0]        ft;
        logic [35:0]        fr;
        logic signed [37:0] num0;
        logic signed [37:0] num1;
        logic [37:0]        den0;
        logic [37:0]        den1;
        dv_t [1:0]          dv;
        logic signed [25:0] c0;
        logic signed [25:0] c1;
        cr_t [3:0]          cr;
        logic signed [14:0] hip;
        logic signed [15:0] femur;
        logic [13:0]        knee;
    } item_t;

    function automatic item_t f_load(logic signed [14:0] tx, logic signed [14:0] ty,
                                     logic signed [14:0] tz, cfg_t cfg);
        item_t r;
        r = '0;
        r.rel_x = 16'(tx) - 16'(cfg.off_x);
        r.rel_y = 16'(ty) - 16'(cfg.off_y);
        r.pz    = -(20'(tz) <<< 4);
        return r;
    endfunction

    function automatic item_t f_mul(item_t a, cfg_t cfg);
        item_t r;
        r = a;
        r.m_xc = 32'(a.rel_x) * 32'(cfg.cosine);
        r.m_ys = 32'(a.rel_y) * 32'(cfg.sine);
        r.m_yc = 32'(a.rel_y) * 32'(cfg.cosine);
        r.m_xs = 32'(a.rel_x) * 32'(cfg.sine);
        return r;
    endfunction

    function automatic item_t f_rot(item_t a);
        item_t r;
        logic signed [33:0] sx;
        logic signed [33:0] sy;
        r = a;
        sx = 34'(a.m_xc) + 34'(a.m_ys) + 34'sd512;
        sy = 34'(a.m_yc) - 34'(a.m_xs) + 34'sd512;
        r.px = 23'(sx >>> 10);
        r.py = -23'(sy >>> 10);
        return r;
    endfunction

    function automatic item_t f_sqxy(item_t a);
        item_t r;
        logic signed [45:0] p;
        logic signed [45:0] q;
        r = a;
        p = 46'(a.px) * 46'(a.px);
        q = 46'(a.py) * 46'(a.py);
        r.sa = 49'($unsigned(p));
        r.sb = 49'($unsigned(q));
        return r;
    endfunction

    function automatic item_t f_sum(item_t a);
        item_t r;
        r = a;
        r.sq[0].rem  = 50'(a.sa) + 50'(a.sb);
        r.sq[0].root = '0;
        return r;
    endfunction

    function automatic sq_t sqrt_step(sq_t a, int k);
        sq_t r;
        logic [49:0] trial;
        r = a;
        trial = (50'(a.root) << (k + 1)) | (50'd1 << (2 * k));
        if (a.rem >= trial) begin
            r.rem  = a.rem - trial;
            r.root = a.root | (25'd1 << k);
        end
        return r;
    endfunction

    function automatic item_t sqrt_item(item_t a, int k);
        item_t r;
        r = a;
        r.sq[0] = sqrt_step(a.sq[0], k);
        r.sq[1] = sqrt_step(a.sq[1], k);
        return r;
    endfunction

    function automatic logic [24:0] sq_round(sq_t a);
        return a.root + 25'(a.rem > 50'(a.root));
    endfunction

    function automatic item_t f_radial(item_t a, cfg_t cfg);
        item_t r;
        r = a;
        r.radial = $signed(26'(sq_round(a.sq[0])) - 26'({cfg.coxa, 4'b0}));
        return r;
    endfunction

    function automatic item_t f_sqrz(item_t a);
        item_t r;
        logic signed [51:0] p;
        logic signed [39:0] q;
        r = a;
        p = 52'(a.radial) * 52'(a.radial);
        q = 40'(a.pz) * 40'(a.pz);
        r.sa = 49'($unsigned(p));
        r.sb = 49'($unsigned(q));
        return r;
    endfunction

    function automatic item_t f_reach(item_t a, cfg_t cfg);
        item_t r;
        logic [24:0] rch;
        logic [18:0] limit;
        r = a;
        rch = sq_round(a.sq[0]);
        limit = 19'({cfg.femur, 4'b0}) + 19'({cfg.tibia, 4'b0});
        if (rch > 25'(limit)) begin
            r.reach = limit;
            r.ok    = 1'b0;
        end else begin
            r.reach = 19'(rch);
            r.ok    = 1'b1;
        end
        r.rz = (r.reach == '0);
        return r;
    endfunction

    function automatic item_t f_lawmul(item_t a, cfg_t cfg);
        item_t r;
        logic [16:0] fem;
        logic [16:0] tib;
        r = a;
        fem = {cfg.femur, 4'b0};
        tib = {cfg.tibia, 4'b0};
        r.r2 = 36'(a.reach) * 36'(a.reach);
        r.f2 = 36'(fem) * 36'(fem);
        r.t2 = 36'(tib) * 36'(tib);
        r.ft = 36'(fem) * 36'(tib);
        r.fr = 36'(fem) * 36'(a.reach);
        return r;
    endfunction

    function automatic item_t f_lawsum(item_t a);
        item_t r;
        r = a;
        r.num0 = $signed(38'(a.f2)) + $signed(38'(a.t2)) - $signed(38'(a.r2));
        r.num1 = $signed(38'(a.f2)) + $signed(38'(a.r2)) - $signed(38'(a.t2));
        r.den0 = 38'(a.ft) << 1;
        r.den1 = 38'(a.fr) << 1;
        return r;
    endfunction

    function automatic dv_t div_prep(logic signed [37:0] num, logic [37:0] den);
        dv_t r;
        logic [37:0] mag;
        r.neg = (num < 0);
        mag = r.neg ? 38'($unsigned(-num)) : 38'($unsigned(num));
        r.dz  = (den == '0);
        r.den = den;
        r.rem = (64'(mag) << 24) + 64'(den >> 1);
        r.sat = (r.rem >= (64'(den) << DIV_BITS));
        r.q   = '0;
        return r;
    endfunction

    function automatic item_t f_divprep(item_t a);
        item_t r;
        r = a;
        r.dv[0] = div_prep(a.num0, a.den0);
        r.dv[1] = div_prep(a.num1, a.den1);
        return r;
    endfunction

    function automatic dv_t div_step(dv_t a, int k);
        dv_t r;
        logic [63:0] d;
        r = a;
        d = 64'(a.den) << k;
        if (a.rem >= d) begin
            r.rem = a.rem - d;
            r.q   = a.q | (25'd1 << k);
        end
        return r;
    endfunction

    function automatic item_t div_item(item_t a, int k);
        item_t r;
        r = a;
        r.dv[0] = div_step(a.dv[0], k);
        r.dv[1] = div_step(a.dv[1], k);
        return r;
    endfunction

    function automatic logic signed [25:0] cos_of(dv_t d);
        logic [25:0] m;
        m = (d.sat || (d.q > 25'd16777216)) ? 26'd16777216 : 26'(d.q);
        if (d.dz) begin
            return COS_ONE;
        end
        return d.neg ? -$signed(m) : $signed(m);
    endfunction

    function automatic item_t f_cos(item_t a);
        item_t r;
        r = a;
        r.c0 = cos_of(a.dv[0]);
        r.c1 = cos_of(a.dv[1]);
        return r;
    endfunction

    function automatic item_t f_csq(item_t a);
        item_t r;
        logic signed [51:0] p;
        logic signed [51:0] q;
        r = a;
        p = 52'(a.c0) * 52'(a.c0);
        q = 52'(a.c1) * 52'(a.c1);
        r.sa = 49'($unsigned(p));
        r.sb = 49'($unsigned(q));
        return r;
    endfunction

    function automatic item_t f_acosin(item_t a);
        item_t r;
        r = a;
        r.sq[0].rem  = SQ_ONE - 50'(a.sa);
        r.sq[0].root = '0;
        r.sq[1].rem  = SQ_ONE - 50'(a.sb);
        r.sq[1].root = '0;
        return r;
    endfunction

    function automatic cr_t cordic_pre(logic signed [35:0] y, logic signed [35:0] x);
        cr_t r;
        logic signed [35:0] xs;
        logic signed [35:0] ys;
        r.zero = (x == '0) && (y == '0);
        xs = x <<< 8;
        ys = y <<< 8;
        if (xs < 0) begin
            if (ys >= 0) begin
                r.x   = ys;
                r.y   = -xs;
                r.ang = HALF_PI_Q30;
            end else begin
                r.x   = -ys;
                r.y   = xs;
                r.ang = -HALF_PI_Q30;
            end
        end else begin
            r.x   = xs;
            r.y   = ys;
            r.ang = '0;
        end
        return r;
    endfunction

    function automatic item_t f_cordin(item_t a);
        item_t r;
        r = a;
        r.cr[0] = cordic_pre(36'(a.py), 36'(a.px));
        r.cr[1] = cordic_pre(36'(a.pz), 36'(a.radial));
        r.cr[2] = cordic_pre($signed(36'(sq_round(a.sq[0]))), 36'(a.c0));
        r.cr[3] = cordic_pre($signed(36'(sq_round(a.sq[1]))), 36'(a.c1));
        return r;
    endfunction

    function automatic cr_t cordic_step(cr_t a, int i);
        cr_t r;
        logic signed [35:0] xs;
        logic signed [35:0] ys;
        logic signed [34:0] at;
        r = a;
        xs = a.x >>> i;
        ys = a.y >>> i;
        at = $signed(35'(ATAN_Q30[i]));
        if (a.y > 0) begin
            r.x   = a.x + ys;
            r.y   = a.y - xs;
            r.ang = a.ang + at;
        end else begin
            r.x   = a.x - ys;
            r.y   = a.y + xs;
            r.ang = a.ang - at;
        end
        return r;
    endfunction

    function automatic item_t cordic_item(item_t a, int i);
        item_t r;
        r = a;
        for (int l = 0; l < 4; l++) begin
            r.cr[l] = cordic_step(a.cr[l], i);
        end
        return r;
    endfunction

    function automatic logic signed [36:0] round_q30(logic signed [36:0] v, int af);
        return (v + (37'sd1 <<< (29 - af))) >>> (30 - af);
    endfunction

    function automatic logic signed [36:0] to_out(logic signed [36:0] v,
                                                  logic signed [36:0] lo,
                                                  logic signed [36:0] hi, int af);
        logic signed [36:0] t;
        t = round_q30(v, af);
        if (t < lo) begin
            t = lo;
        end
        if (t > hi) begin
            t = hi;
        end
        return t;
    endfunction

    function automatic item_t f_out(item_t a, int af);
        item_t r;
        logic signed [36:0] pq;
        logic signed [36:0] h;
        logic signed [36:0] e;
        logic signed [36:0] o;
        logic signed [36:0] k;
        r = a;
        pq = round_q30(PI_Q30, af);
        h = a.cr[0].zero ? 37'sd0 : 37'(a.cr[0].ang);
        e = a.cr[1].zero ? 37'sd0 : 37'(a.cr[1].ang);
        k = a.cr[2].zero ? 37'sd0 : 37'(a.cr[2].ang);
        o = (a.cr[3].zero || a.rz) ? 37'sd0 : 37'(a.cr[3].ang);
        r.hip   = 15'(to_out(h, -pq, pq, af));
        r.femur = 16'(to_out(e - o, -(pq <<< 1), pq, af));
        r.knee  = 14'(to_out(PI_Q30 - k, 37'sd0, pq, af));
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/lik_pipe.sv
// Pipelined datapath of the leg inverse kinematics block: rotation, square roots,
// law-of-cosines dividers and CORDIC vectoring lanes. Depends on lik_pkg.
`default_nettype none

module lik_pipe #(
    parameter int ANGLE_FRAC_BITS   = lik_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_ITERATIONS = lik_pkg::CORDIC_ITERATIONS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire logic signed [14:0] target_x,
    input  wire logic signed [14:0] target_y,
    input  wire logic signed [14:0] target_z,
    input  wire lik_pkg::cfg_t      cfg,
    output logic                    out_valid,
    output logic signed [14:0]      hip_angle,
    output logic signed [15:0]      femur_angle,
    output logic [13:0]             knee_angle,
    output logic                    reachable
);
    import lik_pkg::*;

    localparam int ST_MUL    = 1;
    localparam int ST_ROT    = ST_MUL + 1;
    localparam int ST_SQXY   = ST_ROT + 1;
    localparam int ST_SUMH   = ST_SQXY + 1;
    localparam int ST_SQH    = ST_SUMH + 1;
    localparam int ST_RAD    = ST_SQH + SQRT_BITS;
    localparam int ST_SQRZ   = ST_RAD + 1;
    localparam int ST_SUMR   = ST_SQRZ + 1;
    localparam int ST_SQR    = ST_SUMR + 1;
    localparam int ST_REACH  = ST_SQR + SQRT_BITS;
    localparam int ST_LAWMUL = ST_REACH + 1;
    localparam int ST_LAWSUM = ST_LAWMUL + 1;
    localparam int ST_DIVP   = ST_LAWSUM + 1;
    localparam int ST_DIV    = ST_DIVP + 1;
    localparam int ST_COS    = ST_DIV + DIV_BITS;
    localparam int ST_CSQ    = ST_COS + 1;
    localparam int ST_ACIN   = ST_CSQ + 1;
    localparam int ST_SQA    = ST_ACIN + 1;
    localparam int ST_CIN    = ST_SQA + SQRT_BITS;
    localparam int ST_CRD    = ST_CIN + 1;
    localparam int ST_OUT    = ST_CRD + CORDIC_ITERATIONS;
    localparam int DEPTH     = ST_OUT + 1;

    item_t             pipe_reg  [0:DEPTH-1];
    item_t             pipe_next [0:DEPTH-1];
    logic [DEPTH-1:0]  valid_reg;
    logic [DEPTH-1:0]  valid_next;

    for (genvar s = 0; s < DEPTH; s++) begin : g_stage
        if (s == 0) begin : g_load
            assign pipe_next[s] = f_load(target_x, target_y, target_z, cfg);
        end else if (s == ST_MUL) begin : g_mul
            assign pipe_next[s] = f_mul(pipe_reg[s-1], cfg);
        end else if (s == ST_ROT) begin : g_rot
            assign pipe_next[s] = f_rot(pipe_reg[s-1]);
        end else if (s == ST_SQXY) begin : g_sqxy
            assign pipe_next[s] = f_sqxy(pipe_reg[s-1]);
        end else if (s == ST_SUMH || s == ST_SUMR) begin : g_sum
            assign pipe_next[s] = f_sum(pipe_reg[s-1]);
        end else if (s >= ST_SQH && s < ST_RAD) begin : g_sqh
            assign pipe_next[s] = sqrt_item(pipe_reg[s-1], SQRT_BITS - 1 - (s - ST_SQH));
        end else if (s == ST_RAD) begin : g_rad
            assign pipe_next[s] = f_radial(pipe_reg[s-1], cfg);
        end else if (s == ST_SQRZ) begin : g_sqrz
            assign pipe_next[s] = f_sqrz(pipe_reg[s-1]);
        end else if (s >= ST_SQR && s < ST_REACH) begin : g_sqr
            assign pipe_next[s] = sqrt_item(pipe_reg[s-1], SQRT_BITS - 1 - (s - ST_SQR));
        end else if (s == ST_REACH) begin : g_reach
            assign pipe_next[s] = f_reach(pipe_reg[s-1], cfg);
        end else if (s == ST_LAWMUL) begin : g_lawmul
            assign pipe_next[s] = f_lawmul(pipe_reg[s-1], cfg);
        end else if (s == ST_LAWSUM) begin : g_lawsum
            assign pipe_next[s] = f_lawsum(pipe_reg[s-1]);
        end else if (s == ST_DIVP) begin : g_divp
            assign pipe_next[s] = f_divprep(pipe_reg[s-1]);
        end else if (s >= ST_DIV && s < ST_COS) begin : g_div
            assign pipe_next[s] = div_item(pipe_reg[s-1], DIV_BITS - 1 - (s - ST_DIV));
        end else if (s == ST_COS) begin : g_cos
            assign pipe_next[s] = f_cos(pipe_reg[s-1]);
        end else if (s == ST_CSQ) begin : g_csq
            assign pipe_next[s] = f_csq(pipe_reg[s-1]);
        end else if (s == ST_ACIN) begin : g_acin
            assign pipe_next[s] = f_acosin(pipe_reg[s-1]);
        end else if (s >= ST_SQA && s < ST_CIN) begin : g_sqa
            assign pipe_next[s] = sqrt_item(pipe_reg[s-1], SQRT_BITS - 1 - (s - ST_SQA));
        end else if (s == ST_CIN) begin : g_cin
            assign pipe_next[s] = f_cordin(pipe_reg[s-1]);
        end else if (s >= ST_CRD && s < ST_OUT) begin : g_crd
            assign pipe_next[s] = cordic_item(pipe_reg[s-1], s - ST_CRD);
        end else begin : g_out
            assign pipe_next[s] = f_out(pipe_reg[s-1], ANGLE_FRAC_BITS);
        end
    end

    assign valid_next = {valid_reg[DEPTH-2:0], in_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pipe_reg <= pipe_next;
        end
    end

    assign out_valid   = valid_reg[DEPTH-1];
    assign hip_angle   = pipe_reg[DEPTH-1].hip;
    assign femur_angle = pipe_reg[DEPTH-1].femur;
    assign knee_angle  = pipe_reg[DEPTH-1].knee;
    assign reachable   = pipe_reg[DEPTH-1].ok;

endmodule

`default_nettype wire

>>> hw/rtl/leg_inverse_kinematics.sv
// Top level of the leg inverse kinematics block: stream ports, configuration
// registers and the datapath pipeline. Depends on lik_pkg and lik_pipe.
//
//   Channel  Direction  Contents
//   s_       in         target_x, target_y, target_z (1/16 mm)
//   m_       out        hip_angle, femur_angle, knee_angle, reachable
//   cfg_     in         register index and write data
//
// One target is accepted per cycle unless a result waits unaccepted at the output.
// The pipeline holds three 25-step square-root pipelines, the 25-step divider
// pair and the CORDIC lanes, one register stage each.
// The whole pipeline advances together; it holds while a result waits unaccepted.
// Reset clears all valid bits, loads the default leg geometry and holds both readies low.
`default_nettype none

module leg_inverse_kinematics #(
    parameter int ANGLE_FRAC_BITS   = lik_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_ITERATIONS = lik_pkg::CORDIC_ITERATIONS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // target_x [14:0], target_y [29:15], target_z [44:30], zeros above
    input  wire logic [lik_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // hip_angle [14:0], femur_angle [30:15], knee_angle [44:31], zeros above
    output logic [lik_pkg::M_TDATA_W-1:0]         m_tdata,
    // reachable [0]
    output logic                                  m_tuser,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [lik_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [lik_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import lik_pkg::*;

    cfg_t               cfg_reg;
    cfg_t               cfg_next;
    logic               en;
    logic signed [14:0] hip_angle;
    logic signed [15:0] femur_angle;
    logic [13:0]        knee_angle;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_COXA:   cfg_next.coxa   = cfg_data[12:0];
                REG_FEMUR:  cfg_next.femur  = cfg_data[12:0];
                REG_TIBIA:  cfg_next.tibia  = cfg_data[12:0];
                REG_OFF_X:  cfg_next.off_x  = $signed(cfg_data[13:0]);
                REG_OFF_Y:  cfg_next.off_y  = $signed(cfg_data[13:0]);
                REG_COSINE: cfg_next.cosine = $signed(cfg_data);
                REG_SINE:   cfg_next.sine   = $signed(cfg_data);
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.coxa   <= 13'd800;
            cfg_reg.femur  <= 13'd1600;
            cfg_reg.tibia  <= 13'd2400;
            cfg_reg.off_x  <= '0;
            cfg_reg.off_y  <= '0;
            cfg_reg.cosine <= 16'sd16384;
            cfg_reg.sine   <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_ready = aresetn;
    assign en        = !m_tvalid || m_tready;
    assign s_tready  = en && aresetn;

    lik_pipe #(
        .ANGLE_FRAC_BITS   (ANGLE_FRAC_BITS),
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    ) u_pipe (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (s_tvalid),
        .target_x    ($signed(s_tdata[14:0])),
        .target_y    ($signed(s_tdata[29:15])),
        .target_z    ($signed(s_tdata[44:30])),
        .cfg         (cfg_reg),
        .out_valid   (m_tvalid),
        .hip_angle   (hip_angle),
        .femur_angle (femur_angle),
        .knee_angle  (knee_angle),
        .reachable   (m_tuser)
    );

    assign m_tdata = {3'b000, knee_angle, femur_angle, hip_angle};

endmodule

`default_nettype wire

>>> hw/rtl/lik_checker.sv
// Port-level checker for the leg inverse kinematics block, bound to the top level.
// Depends on lik_pkg and leg_inverse_kinematics_defines.svh.
`default_nettype none
`include "leg_inverse_kinematics_defines.svh"

module lik_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [lik_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                          m_tuser
);
    import lik_pkg::*;

    // A stalled result keeps its place and its contents.
    `LIK_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "result transaction dropped while stalled")
    `LIK_ASSERT_NEXT(a_out_stable, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "stalled result transaction changed")
    // A stall at the output must stop new targets from entering the pipeline.
    `LIK_ASSERT_NOW(a_stall_back, aclk, aresetn, m_tvalid && !m_tready, !s_tready && (s_tvalid || !s_tvalid), "target accepted while the pipeline is stalled")
    // No result is presented in the cycle after reset.
    `LIK_ASSERT_NOW(a_reset_empty, aclk, aresetn, !$past(aresetn), !m_tvalid, "result presented right after reset")

endmodule

bind leg_inverse_kinematics lik_checker u_lik_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

>>> sim/leg_inverse_kinematics_tb.sv
// Self-checking testbench for leg_inverse_kinematics: drives targets and register writes,
// predicts joint angles in a scoreboard class and compares every result transaction.
// Depends on lik_pkg and the leg_inverse_kinematics RTL.
`default_nettype none

module leg_inverse_kinematics_tb;
    import lik_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int PHASE_ITEMS    = 200;

    typedef struct {
        logic [14:0] hip;
        logic [15:0] femur;
        logic [13:0] knee;
        logic        reachable;
    } joint_angles_t;

    class ik_scoreboard;
        longint        geom [7];
        joint_angles_t pending [$];
        int            errors;

        function new();
            geom = '{800, 1600, 2400, 0, 0, 16384, 0};
            errors = 0;
        endfunction

        function void set_register(reg_idx_t idx, logic [15:0] data);
            case (idx)
                REG_COXA, REG_FEMUR, REG_TIBIA: geom[idx] = longint'(data[12:0]);
                REG_OFF_X, REG_OFF_Y: geom[idx] = longint'($signed(data[13:0]));
                default: geom[idx] = longint'($signed(data));
            endcase
        endfunction

        function longint round_down(longint v, int n);
            return (v + (longint'(1) <<< (n - 1))) >>> n;
        endfunction

        function longint root_nearest(longint unsigned v);
            longint unsigned r;
            longint unsigned bitv;
            longint unsigned rest;
            r = 0;
            bitv = 64'd1 << 62;
            rest = v;
            while (bitv > rest) bitv >>= 2;
            while (bitv != 0) begin
                if (rest >= r + bitv) begin
                    rest -= r + bitv;
                    r = (r >> 1) + bitv;
                end else begin
                    r >>= 1;
                end
                bitv >>= 2;
            end
            if (v - r * r > r) r++;
            return longint'(r);
        endfunction

        function longint bearing_q30(longint y, longint x);
            longint ang;
            longint t;
            longint xs;
            longint ys;
            longint steps [24];
            steps = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
                      16775850, 8388437, 4194282, 2097149, 1048575, 524287,
                      262143, 131071, 65535, 32767, 16383, 8191,
                      4095, 2047, 1023, 511, 255, 127};
            ang = 0;
            if (x == 0 && y == 0) return 0;
            x = x * 256;
            y = y * 256;
            if (x < 0) begin
                if (y >= 0) begin
                    t = x; x = y; y = -t; ang = 1686629713;
                end else begin
                    t = x; x = -y; y = t; ang = -1686629713;
                end
            end
            for (int i = 0; i < 16; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y > 0) begin
                    x += ys; y -= xs; ang += steps[i];
                end else begin
                    x -= ys; y += xs; ang -= steps[i];
                end
            end
            return ang;
        endfunction

        function longint arccos_q30(longint c);
            longint one;
            one = longint'(1) <<< 24;
            return bearing_q30(root_nearest(longint'(one * one - c * c)), c);
        endfunction

        function longint cosine_q24(longint num, longint den);
            longint one;
            longint unsigned mag;
            longint c;
            one = longint'(1) <<< 24;
            if (den <= 0) return one;
            mag = (num * one < 0) ? -(num * one) : num * one;
            c = longint'((mag + longint'(den) / 2) / den);
            if (num < 0) c = -c;
            if (c < -one) c = -one;
            if (c > one) c = one;
            return c;
        endfunction

        function longint clamp(longint v, longint lo, longint hi);
            if (v < lo) v = lo;
            if (v > hi) v = hi;
            return v;
        endfunction

        function void note_target(longint tx, longint ty, longint tz);
            longint coxa, fem, tib, rx, ry, px, py, pz, radial, reach, knee_int, offs;
            longint elev, pi_q, pi30;
            joint_angles_t e;
            coxa = geom[REG_COXA] * 16;
            fem = geom[REG_FEMUR] * 16;
            tib = geom[REG_TIBIA] * 16;
            rx = tx - geom[REG_OFF_X];
            ry = ty - geom[REG_OFF_Y];
            px = round_down(rx * geom[REG_COSINE] + ry * geom[REG_SINE], 10);
            py = -round_down(ry * geom[REG_COSINE] - rx * geom[REG_SINE], 10);
            pz = -(tz * 16);
            radial = root_nearest(px * px + py * py) - coxa;
            reach = root_nearest(radial * radial + pz * pz);
            e.reachable = 1'b1;
            if (reach > fem + tib) begin
                reach = fem + tib;
                e.reachable = 1'b0;
            end
            knee_int = arccos_q30(cosine_q24(fem * fem + tib * tib - reach * reach,
                                             2 * fem * tib));
            offs = (reach == 0) ? 0 :
                   arccos_q30(cosine_q24(fem * fem + reach * reach - tib * tib,
                                         2 * fem * reach));
            elev = bearing_q30(pz, radial);
            pi30 = 64'd3373259426;
            pi_q = round_down(pi30, 18);
            e.hip   = 15'(clamp(round_down(bearing_q30(py, px), 18), -pi_q, pi_q));
            e.femur = 16'(clamp(round_down(elev - offs, 18), -2 * pi_q, pi_q));
            e.knee  = 14'(clamp(round_down(pi30 - knee_int, 18), 0, pi_q));
            pending.push_back(e);
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] data, logic reach_flag);
            joint_angles_t e;
            if (pending.size() == 0) begin
                $error("unexpected result transaction: tdata %h", data);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (data[14:0] !== e.hip) begin
                $error("hip_angle: expected %0d, actual %0d", $signed(e.hip),
                       $signed(data[14:0]));
                errors++;
            end
            if (data[30:15] !== e.femur) begin
                $error("femur_angle: expected %0d, actual %0d", $signed(e.femur),
                       $signed(data[30:15]));
                errors++;
            end
            if (data[44:31] !== e.knee) begin
                $error("knee_angle: expected %0d, actual %0d", e.knee, data[44:31]);
                errors++;
            end
            if (reach_flag !== e.reachable) begin
                $error("reachable: expected %0d, actual %0d", e.reachable, reach_flag);
                errors++;
            end
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tuser;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    ik_scoreboard sb;
    int           send_idle_pct;
    int           recv_stall_pct;
    int           quiet_cycles;

    leg_inverse_kinematics u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata, m_tuser);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
            || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("leg_inverse_kinematics: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(reg_idx_t idx, int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 16'(value);
        do @(posedge aclk); while (!cfg_ready);
        sb.set_register(idx, 16'(value));
    endtask

    task automatic send_target(int tx, int ty, int tz);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b0, 15'(tz), 15'(ty), 15'(tx)};
        do @(posedge aclk); while (!s_tready);
        sb.note_target(tx, ty, tz);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic int fit_coord(int v);
        return (v < -16384) ? -16384 : (v > 16383) ? 16383 : v;
    endfunction

    task automatic load_geometry(int set_no);
        case (set_no)
            1: begin
                write_reg(REG_COXA, 0);      write_reg(REG_FEMUR, 1);
                write_reg(REG_TIBIA, 1);     write_reg(REG_OFF_X, -8192);
                write_reg(REG_OFF_Y, -8192); write_reg(REG_COSINE, -16384);
                write_reg(REG_SINE, 16384);
            end
            2: begin
                write_reg(REG_COXA, 8191);   write_reg(REG_FEMUR, 8191);
                write_reg(REG_TIBIA, 8191);  write_reg(REG_OFF_X, 8191);
                write_reg(REG_OFF_Y, 8191);  write_reg(REG_COSINE, 16384);
                write_reg(REG_SINE, -16384);
            end
            3: begin
                write_reg(REG_COXA, 800);    write_reg(REG_FEMUR, 1600);
                write_reg(REG_TIBIA, 2400);  write_reg(REG_OFF_X, 0);
                write_reg(REG_OFF_Y, 0);     write_reg(REG_COSINE, 16384);
                write_reg(REG_SINE, 0);
            end
            default: begin
                write_reg(REG_COXA, $urandom_range(1500));
                write_reg(REG_FEMUR, $urandom_range(3000, 1));
                write_reg(REG_TIBIA, $urandom_range(3000, 1));
                write_reg(REG_OFF_X, int'($urandom_range(8000)) - 4000);
                write_reg(REG_OFF_Y, int'($urandom_range(8000)) - 4000);
                write_reg(REG_COSINE, int'($urandom_range(32768)) - 16384);
                write_reg(REG_SINE, int'($urandom_range(32768)) - 16384);
            end
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(int n, int drain_at);
        int span;
        for (int i = 0; i < n; i++) begin
            if (i == drain_at) wait_for_results();
            span = int'(sb.geom[REG_COXA] + sb.geom[REG_FEMUR] + sb.geom[REG_TIBIA]);
            if ($urandom_range(99) < 65) begin
                send_target(fit_coord(int'(sb.geom[REG_OFF_X]) + int'($urandom_range(2 * span)) - span),
                            fit_coord(int'(sb.geom[REG_OFF_Y]) + int'($urandom_range(2 * span)) - span),
                            fit_coord(int'($urandom_range(2 * span)) - span));
            end else begin
                send_target(int'($urandom_range(32767)) - 16384,
                            int'($urandom_range(32767)) - 16384,
                            int'($urandom_range(32767)) - 16384);
            end
        end
    endtask

    initial begin
        sb = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        quiet_cycles   = 0;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_COXA;
        cfg_data  <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_target(0, 0, 0);
        send_target(800, 0, 0);
        send_target(-16384, -16384, -16384);
        send_target(16383, 16383, 16383);
        send_target(16383, 0, 0);
        send_target(3200, 0, 1600);
        send_target(2000, 500, -1000);
        send_target(-1000, 0, 0);
        send_target(-1000, -5, 0);
        send_target(0, -1000, 0);
        send_target(0, 1000, 0);
        send_target(-16384, 16383, 0);
        send_target(800, 0, 16383);
        send_target(4800, 0, 0);
        send_target(0, 0, -16384);
        wait_for_results();

        for (int p = 0; p < 7; p++) begin
            load_geometry(p);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            random_phase(PHASE_ITEMS, (p == 3) ? PHASE_ITEMS / 2 : -1);
            wait_for_results();
        end

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("leg_inverse_kinematics: match");
        end else begin
            $display("leg_inverse_kinematics: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire
